/* src/pl0_pkg.sv */
// shared types, codes and constants of the p-code executor
package pl0_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int CODE_DEPTH      = 2048;
  localparam int PC_W            = 11;
  localparam int MAX_NESTING     = 7;
  localparam int RESET_TOP       = 3;
  localparam int RESET_BASE      = 1;

  typedef enum logic [2:0] {
    FN_LIT = 3'd0,
    FN_OPR = 3'd1,
    FN_LOD = 3'd2,
    FN_STO = 3'd3,
    FN_CAL = 3'd4,
    FN_INT = 3'd5,
    FN_JMP = 3'd6,
    FN_JPC = 3'd7
  } fn_t;

  // opr sub-operations
  localparam logic [31:0] OPR_RET = 32'd0;
  localparam logic [31:0] OPR_NEG = 32'd1;
  localparam logic [31:0] OPR_ADD = 32'd2;
  localparam logic [31:0] OPR_SUB = 32'd3;
  localparam logic [31:0] OPR_MUL = 32'd4;
  localparam logic [31:0] OPR_DIV = 32'd5;
  localparam logic [31:0] OPR_ODD = 32'd6;
  localparam logic [31:0] OPR_EQU = 32'd7;
  localparam logic [31:0] OPR_NEQ = 32'd8;
  localparam logic [31:0] OPR_LES = 32'd9;
  localparam logic [31:0] OPR_GEQ = 32'd10;
  localparam logic [31:0] OPR_GTR = 32'd11;
  localparam logic [31:0] OPR_LEQ = 32'd12;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_LINKW,
    S_PREP,
    S_RD1,
    S_RD2,
    S_DIV,
    S_EXEC,
    S_WR2,
    S_WR3,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_wr;
    logic       load_ir;
    logic       link_rd;
    logic       link_step;
    logic       prep_rd;
    logic       rd1;
    logic       rd2;
    logic       div_start;
    logic       exec;
    logic       commit;
    logic       wr2;
    logic       wr3;
    logic       fault;
    logic [1:0] fault_code;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic stopped;
    logic link_op;
    logic lv_err;
    logic lvcnt_zero;
    logic lvcnt_one;
    logic link_err;
    logic prep_err;
    logic need_rd1;
    logic need_rd2;
    logic is_div;
    logic div_zero;
    logic div_done;
    logic exec_err;
    logic is_cal;
    logic out_free;
  } stat_t;

endpackage

/* src/pl0_div.sv */
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
module pl0_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] sh;
  logic [32:0] diff;

  // one restoring step
  assign sh   = {rem, quo[31]};
  assign diff = sh - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitudes and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor[31] ? 32'd0 - divisor : divisor;
      quo <= dividend[31] ? 32'd0 - dividend : dividend;
      rem <= '0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? 32'd0 - quo : quo;

endmodule

/* src/pl0_ctrl.sv */
// controller state machine that sequences each instruction
module pl0_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pl0_pkg::stat_t st,
  output pl0_pkg::cmd_t  cmd
);
  import pl0_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (st.clr_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (st.stopped) state_next = S_FIN;
        else if (st.link_op && st.lv_err) state_next = S_FIN;
        else if (st.link_op && !st.lvcnt_zero) state_next = S_LINK;
        else state_next = S_PREP;
      end
      S_LINK:   state_next = st.link_err ? S_FIN : S_LINKW;
      S_LINKW:  state_next = st.lvcnt_one ? S_PREP : S_LINK;
      S_PREP: begin
        if (st.prep_err) state_next = S_FIN;
        else if (st.need_rd1) state_next = S_RD1;
        else state_next = S_EXEC;
      end
      S_RD1:    state_next = st.need_rd2 ? S_RD2 : S_EXEC;
      S_RD2: begin
        if (st.is_div && st.div_zero) state_next = S_FIN;
        else if (st.is_div) state_next = S_DIV;
        else state_next = S_EXEC;
      end
      S_DIV:    if (st.div_done) state_next = S_EXEC;
      S_EXEC: begin
        if (st.exec_err) state_next = S_FIN;
        else if (st.is_cal) state_next = S_WR2;
        else state_next = S_FIN;
      end
      S_WR2:    state_next = S_WR3;
      S_WR3:    state_next = S_FIN;
      S_FIN:    if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR:  cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_ir = in_valid;
      end
      S_DECODE: begin
        if (!st.stopped && st.link_op && st.lv_err) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_RANGE;
        end
      end
      S_LINK: begin
        if (st.link_err) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_RANGE;
        end else begin
          cmd.link_rd = 1'b1;
        end
      end
      S_LINKW:  cmd.link_step = 1'b1;
      S_PREP: begin
        if (st.prep_err) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_RANGE;
        end else begin
          cmd.prep_rd = st.need_rd1;
        end
      end
      S_RD1:    cmd.rd1 = 1'b1;
      S_RD2: begin
        cmd.rd2 = 1'b1;
        if (st.is_div && st.div_zero) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_DIV0;
        end else begin
          cmd.div_start = st.is_div;
        end
      end
      S_EXEC: begin
        if (st.exec_err) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_RANGE;
        end else begin
          cmd.exec   = 1'b1;
          cmd.commit = !st.is_cal;
        end
      end
      S_WR2:    cmd.wr2 = 1'b1;
      S_WR3: begin
        cmd.wr3    = 1'b1;
        cmd.commit = 1'b1;
      end
      S_FIN:    cmd.out_load = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

/* src/pl0_dp.sv */
// datapath: stack memory, machine registers, alu, divider and result register
module pl0_dp #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pl0_pkg::cmd_t             cmd,
  output pl0_pkg::stat_t            st,
  input  logic [2:0]                function_code,
  input  logic [2:0]                level_diff,
  input  logic signed [31:0]        operand,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pl0_pkg::PC_W-1:0]  next_pc,
  output logic                      halted,
  output logic                      store_valid,
  output logic signed [31:0]        store_value,
  output logic [1:0]                status
);
  import pl0_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic signed [33:0] DEPTH_W = 34'(STACK_DEPTH);

  function automatic logic in_stack(input logic signed [33:0] v);
    return (v >= 34'sd0) && (v < DEPTH_W);
  endfunction

  // machine state
  logic [AW-1:0]   top;
  logic [AW-1:0]   b;
  logic [PC_W-1:0] pc;
  logic            stopped;
  logic [1:0]      held;
  logic [AW-1:0]   clr_cnt;

  // current instruction and operands
  fn_t         fn;
  logic [2:0]  lv;
  logic [31:0] a;
  logic [31:0] base;
  logic [2:0]  lvcnt;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] rdata;
  logic        sv_valid;
  logic [31:0] sv_value;

  // stack memory
  logic [31:0] mem [STACK_DEPTH];
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  // wide address arithmetic
  logic signed [33:0] topw, bw, aw, basew, nbw;
  logic signed [33:0] t_p1, t_p2, t_p3, t_m1, b_m1, b_p1, b_p2, t_pa, idx;
  logic opr_ret, opr_un, opr_bin, opr_div;
  logic [PC_W-1:0] pc_inc;
  logic [PC_W-1:0] target;

  // alu
  logic [31:0] mul_lo;
  logic [31:0] bin_r;
  logic        div_done;
  logic [31:0] div_q;

  // commit values
  logic [AW-1:0]   top_new;
  logic [AW-1:0]   b_new;
  logic [PC_W-1:0] pc_new;
  logic            prep_err;
  logic            need_rd1;
  logic [AW-1:0]   rd1_addr;
  logic [AW-1:0]   rd2_addr;
  logic            ex_we;
  logic [AW-1:0]   ex_addr;
  logic [31:0]     ex_data;

  assign topw  = $signed({{(34-AW){1'b0}}, top});
  assign bw    = $signed({{(34-AW){1'b0}}, b});
  assign aw    = $signed({{2{a[31]}}, a});
  assign basew = $signed({{2{base[31]}}, base});
  assign nbw   = $signed({{2{x[31]}}, x});
  assign t_p1  = topw + 34'sd1;
  assign t_p2  = topw + 34'sd2;
  assign t_p3  = topw + 34'sd3;
  assign t_m1  = topw - 34'sd1;
  assign b_m1  = bw - 34'sd1;
  assign b_p1  = bw + 34'sd1;
  assign b_p2  = bw + 34'sd2;
  assign t_pa  = topw + aw;
  assign idx   = basew + aw;
  assign pc_inc = pc + PC_W'(1);
  assign target = a[PC_W-1:0];

  // opr classes
  assign opr_ret = (fn == FN_OPR) && (a == OPR_RET);
  assign opr_un  = (fn == FN_OPR) && ((a == OPR_NEG) || (a == OPR_ODD));
  assign opr_bin = (fn == FN_OPR) && ($signed(a) >= $signed(OPR_ADD))
                   && ($signed(a) <= $signed(OPR_LEQ)) && (a != OPR_ODD);
  assign opr_div = (fn == FN_OPR) && (a == OPR_DIV);

  // range checks before any access
  always_comb begin
    prep_err = 1'b0;
    case (fn)
      FN_LIT: prep_err = !in_stack(t_p1);
      FN_OPR: begin
        if (opr_ret) prep_err = !in_stack(b_m1) || !in_stack(b_p2);
        else if (opr_un) prep_err = !in_stack(topw);
        else if (opr_bin) prep_err = !in_stack(t_m1) || !in_stack(topw);
      end
      FN_LOD: prep_err = !in_stack(idx) || !in_stack(t_p1);
      FN_STO: prep_err = !in_stack(idx) || !in_stack(t_m1);
      FN_CAL: prep_err = !in_stack(t_p3) || !in_stack(t_p1);
      FN_INT: prep_err = !in_stack(t_pa);
      FN_JPC: prep_err = !in_stack(t_m1) || !in_stack(topw);
      default: prep_err = 1'b0;
    endcase
  end

  // operand reads
  always_comb begin
    need_rd1 = 1'b0;
    rd1_addr = top;
    rd2_addr = top;
    if (opr_ret) begin
      need_rd1 = 1'b1;
      rd1_addr = b_p1[AW-1:0];
      rd2_addr = b_p2[AW-1:0];
    end else if (opr_un) begin
      need_rd1 = 1'b1;
    end else if (opr_bin) begin
      need_rd1 = 1'b1;
      rd1_addr = t_m1[AW-1:0];
    end else if (fn == FN_LOD) begin
      need_rd1 = 1'b1;
      rd1_addr = idx[AW-1:0];
    end else if (fn inside {FN_STO, FN_JPC}) begin
      need_rd1 = 1'b1;
    end
  end

  // binary opr result
  assign mul_lo = x * y;
  always_comb begin
    case (a)
      OPR_ADD: bin_r = x + y;
      OPR_SUB: bin_r = x - y;
      OPR_MUL: bin_r = mul_lo;
      OPR_DIV: bin_r = div_q;
      OPR_EQU: bin_r = {31'd0, x == y};
      OPR_NEQ: bin_r = {31'd0, x != y};
      OPR_LES: bin_r = {31'd0, $signed(x) < $signed(y)};
      OPR_GEQ: bin_r = {31'd0, $signed(x) >= $signed(y)};
      OPR_GTR: bin_r = {31'd0, $signed(x) > $signed(y)};
      default: bin_r = {31'd0, $signed(x) <= $signed(y)};
    endcase
  end

  pl0_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (x),
    .divisor  (rdata),
    .done     (div_done),
    .quotient (div_q)
  );

  // execute: first write and new machine state
  always_comb begin
    ex_we   = 1'b0;
    ex_addr = top;
    ex_data = x;
    top_new = top;
    b_new   = b;
    pc_new  = pc_inc;
    case (fn)
      FN_LIT: begin
        ex_we   = 1'b1;
        ex_addr = t_p1[AW-1:0];
        ex_data = a;
        top_new = t_p1[AW-1:0];
      end
      FN_OPR: begin
        if (opr_ret) begin
          top_new = b_m1[AW-1:0];
          b_new   = x[AW-1:0];
          pc_new  = y[PC_W-1:0];
        end else if (opr_un) begin
          ex_we   = 1'b1;
          ex_data = (a == OPR_NEG) ? 32'd0 - x : {31'd0, x[0]};
        end else if (opr_bin) begin
          ex_we   = 1'b1;
          ex_addr = t_m1[AW-1:0];
          ex_data = bin_r;
          top_new = t_m1[AW-1:0];
        end
      end
      FN_LOD: begin
        ex_we   = 1'b1;
        ex_addr = t_p1[AW-1:0];
        top_new = t_p1[AW-1:0];
      end
      FN_STO: begin
        ex_we   = 1'b1;
        ex_addr = idx[AW-1:0];
        top_new = t_m1[AW-1:0];
      end
      FN_CAL: begin
        ex_we   = 1'b1;
        ex_addr = t_p1[AW-1:0];
        ex_data = base;
        b_new   = t_p1[AW-1:0];
        pc_new  = target;
      end
      FN_INT: top_new = t_pa[AW-1:0];
      FN_JMP: pc_new = target;
      FN_JPC: begin
        top_new = t_m1[AW-1:0];
        if (x == 32'd0) pc_new = target;
      end
      default: ex_we = 1'b0;
    endcase
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = ex_addr;
    wdata = ex_data;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.exec) begin
      we = ex_we;
    end else if (cmd.wr2) begin
      we    = 1'b1;
      waddr = t_p2[AW-1:0];
      wdata = {{(32-AW){1'b0}}, b};
    end else if (cmd.wr3) begin
      we    = 1'b1;
      waddr = t_p3[AW-1:0];
      wdata = {{(32-PC_W){1'b0}}, pc_inc};
    end
  end

  always_comb begin
    re = cmd.link_rd || cmd.prep_rd || cmd.rd1;
    if (cmd.link_rd) raddr = base[AW-1:0];
    else if (cmd.prep_rd) raddr = rd1_addr;
    else raddr = rd2_addr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // machine control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= AW'(RESET_TOP);
      b         <= AW'(RESET_BASE);
      pc        <= '0;
      stopped   <= 1'b0;
      held      <= ST_OK;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.commit) begin
        top <= top_new;
        b   <= b_new;
        pc  <= pc_new;
        if (pc_new == '0) begin
          stopped <= 1'b1;
          held    <= ST_OK;
        end
      end
      if (cmd.fault) begin
        stopped <= 1'b1;
        held    <= cmd.fault_code;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // instruction, operands and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_ir) begin
      fn       <= fn_t'(function_code);
      lv       <= level_diff;
      a        <= operand;
      base     <= {{(32-AW){1'b0}}, b};
      lvcnt    <= level_diff;
      sv_valid <= 1'b0;
      sv_value <= '0;
    end
    if (cmd.link_step) begin
      base  <= rdata;
      lvcnt <= lvcnt - 3'd1;
    end
    if (cmd.rd1) x <= rdata;
    if (cmd.rd2) y <= rdata;
    if (cmd.commit && (fn == FN_STO)) begin
      sv_valid <= 1'b1;
      sv_value <= x;
    end
    if (cmd.out_load) begin
      next_pc     <= pc;
      halted      <= stopped;
      store_valid <= sv_valid;
      store_value <= sv_value;
      status      <= held;
    end
  end

  // status to controller
  always_comb begin
    st            = '0;
    st.clr_done   = (clr_cnt == AW'(STACK_DEPTH - 1));
    st.stopped    = stopped;
    st.link_op    = fn inside {FN_LOD, FN_STO, FN_CAL};
    st.lv_err     = int'(lv) > MAX_NESTING;
    st.lvcnt_zero = (lvcnt == 3'd0);
    st.lvcnt_one  = (lvcnt == 3'd1);
    st.link_err   = !in_stack(basew);
    st.prep_err   = prep_err;
    st.need_rd1   = need_rd1;
    st.need_rd2   = opr_ret || opr_bin;
    st.is_div     = opr_div;
    st.div_zero   = (rdata == 32'd0);
    st.div_done   = div_done;
    st.exec_err   = opr_ret && !in_stack(nbw);
    st.is_cal     = (fn == FN_CAL);
    st.out_free   = !out_valid || out_ready;
  end

  // once halted the machine stays halted
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("halt state cleared");

  // no state commit after a halt
  a_no_commit_halted: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !stopped) else $error("commit while halted");

  // a running result always reports ok
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !halted |-> status == ST_OK) else $error("error status without halt");

  // a store result never carries an error
  a_store_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_valid |-> status == ST_OK) else $error("store with error status");

  // top pointer stays inside the stack
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, top} < (AW+1)'(STACK_DEPTH)) else $error("top out of range");

endmodule

/* src/pl0_stack_machine_executor_unit.sv */
// top level of the pl0 p-code executor: controller plus datapath
// Executes one p-code instruction per input transaction and returns one result
// transaction with the next code address to fetch. After reset the stack memory
// is swept to zero, during which in_ready stays low. Each instruction then goes
// through decode, range check, up to two stack reads through the single
// registered read port, execute and result load, with link reads per static
// link level for LOD, STO and CAL, extra frame writes for CAL, and the
// bit-serial divider for DIV. One instruction is in flight at a time; the next
// is accepted while the previous result still sits in the output register.
// After a halt every instruction is answered with the halted address and the
// latched status.
module pl0_stack_machine_executor_unit #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                function_code,
  input  logic [2:0]                level_diff,
  input  logic signed [31:0]        operand,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pl0_pkg::PC_W-1:0]  next_pc,
  output logic                      halted,
  output logic                      store_valid,
  output logic signed [31:0]        store_value,
  output logic [1:0]                status
);
  import pl0_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pl0_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pl0_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .function_code (function_code),
    .level_diff    (level_diff),
    .operand       (operand),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_pc       (next_pc),
    .halted        (halted),
    .store_valid   (store_valid),
    .store_value   (store_value),
    .status        (status)
  );

endmodule

/* dv/tb_pl0_stack_machine_executor_unit.sv */
// self-checking testbench of the pl0 p-code executor with a built-in machine predictor
module tb_pl0_stack_machine_executor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pl0_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int N_RANDOM = 500;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            hlt;
    logic            sto;
    logic [31:0]     val;
    logic [1:0]      st;
  } instr_res_t;

  typedef struct packed {
    logic [2:0]      f;
    logic [2:0]      lv;
    logic [31:0]     op;
    logic            typed;
    logic [PC_W-1:0] pc;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] function_code, level_diff;
  logic signed [31:0] operand;
  logic [PC_W-1:0] next_pc;
  logic halted, store_valid;
  logic signed [31:0] store_value;
  logic [1:0] status;

  // predicted machine state
  logic [31:0]     mem [DEPTH];
  logic [31:0]     mem_save [DEPTH];
  longint          m_top, m_base;
  logic [PC_W-1:0] m_pc;
  bit              m_stopped;
  logic [1:0]      m_hst;

  instr_res_t pending_results[$];
  dir_row_t   dir_rows[$];
  int         errors = 0;
  bit         stim_done = 0;

  pl0_stack_machine_executor_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .function_code(function_code), .level_diff(level_diff), .operand(operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .halted(halted), .store_valid(store_valid),
    .store_value(store_value), .status(status)
  );

  function automatic bit inr(longint i);
    return i >= 0 && i < DEPTH;
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // walk static links, 0 on an out-of-range link
  function automatic bit walk_links(longint b0, logic [2:0] lv, output longint res);
    longint bb;
    bb = b0;
    res = 0;
    if (lv > MAX_NESTING) return 0;
    for (int k = 0; k < lv; k++) begin
      if (!inr(bb)) return 0;
      bb = sx(mem[bb]);
    end
    res = bb;
    return 1;
  endfunction

  // execute one instruction on the predicted machine
  function automatic instr_res_t exec_instr(logic [2:0] fc, logic [2:0] lv, logic [31:0] araw);
    longint a, top, b, base, idx, nb;
    logic [PC_W-1:0] nxt, pcv;
    logic [1:0] st;
    logic [31:0] x, y, r, sval;
    bit sv;
    instr_res_t o;
    if (m_stopped) begin
      o = '{m_pc, 1'b1, 1'b0, 32'd0, m_hst};
      return o;
    end
    a = sx(araw);
    top = m_top;
    b = m_base;
    pcv = m_pc;
    nxt = pcv + 1'b1;
    st = ST_OK;
    sval = 0;
    sv = 0;
    r = 0;
    case (fn_t'(fc))
      FN_LIT: begin
        if (!inr(top + 1)) st = ST_RANGE;
        else begin
          mem[top + 1] = araw;
          top++;
        end
      end
      FN_OPR: begin
        if (araw == OPR_RET) begin
          if (!inr(b - 1) || !inr(b + 2)) st = ST_RANGE;
          else begin
            nb = sx(mem[b + 1]);
            if (!inr(nb)) st = ST_RANGE;
            else begin
              nxt = mem[b + 2][PC_W-1:0];
              top = b - 1;
              b = nb;
            end
          end
        end else if (araw == OPR_NEG) begin
          if (!inr(top)) st = ST_RANGE;
          else mem[top] = 32'd0 - mem[top];
        end else if (araw == OPR_ODD) begin
          if (!inr(top)) st = ST_RANGE;
          else mem[top] = mem[top] & 32'd1;
        end else if (a >= sx(OPR_ADD) && a <= sx(OPR_LEQ)) begin
          if (!inr(top - 1) || !inr(top)) st = ST_RANGE;
          else begin
            x = mem[top - 1];
            y = mem[top];
            case (araw)
              OPR_ADD: r = x + y;
              OPR_SUB: r = x - y;
              OPR_MUL: r = x * y;
              OPR_DIV: begin
                if (y == 0) st = ST_DIV0;
                else r = 32'(sx(x) / sx(y));
              end
              OPR_EQU: r = {31'd0, x == y};
              OPR_NEQ: r = {31'd0, x != y};
              OPR_LES: r = {31'd0, sx(x) < sx(y)};
              OPR_GEQ: r = {31'd0, sx(x) >= sx(y)};
              OPR_GTR: r = {31'd0, sx(x) > sx(y)};
              default: r = {31'd0, sx(x) <= sx(y)};
            endcase
            if (st == ST_OK) begin
              top--;
              mem[top] = r;
            end
          end
        end
      end
      FN_LOD: begin
        if (!walk_links(b, lv, base)) st = ST_RANGE;
        else begin
          idx = base + a;
          if (!inr(idx) || !inr(top + 1)) st = ST_RANGE;
          else begin
            mem[top + 1] = mem[idx];
            top++;
          end
        end
      end
      FN_STO: begin
        if (!walk_links(b, lv, base)) st = ST_RANGE;
        else begin
          idx = base + a;
          if (!inr(idx) || !inr(top - 1)) st = ST_RANGE;
          else begin
            sval = mem[top];
            mem[idx] = sval;
            sv = 1;
            top--;
          end
        end
      end
      FN_CAL: begin
        if (!walk_links(b, lv, base)) st = ST_RANGE;
        else if (!inr(top + 3) || !inr(top + 1)) st = ST_RANGE;
        else begin
          mem[top + 1] = 32'(base);
          mem[top + 2] = 32'(b);
          mem[top + 3] = 32'(nxt);
          b = top + 1;
          nxt = araw[PC_W-1:0];
        end
      end
      FN_INT: begin
        if (!inr(top + a)) st = ST_RANGE;
        else top += a;
      end
      FN_JMP: nxt = araw[PC_W-1:0];
      default: begin
        if (!inr(top - 1) || !inr(top)) st = ST_RANGE;
        else begin
          if (mem[top] == 0) nxt = araw[PC_W-1:0];
          top--;
        end
      end
    endcase
    if (st != ST_OK) begin
      m_stopped = 1;
      m_hst = st;
      o = '{pcv, 1'b1, 1'b0, 32'd0, st};
    end else begin
      m_top = top;
      m_base = b;
      m_pc = nxt;
      if (nxt == 0) begin
        m_stopped = 1;
        m_hst = ST_OK;
      end
      o = '{nxt, nxt == 0, sv, sval, ST_OK};
    end
    return o;
  endfunction

  // try an instruction on the predictor and undo it, reports whether it halts
  function automatic bit halts_machine(logic [2:0] fc, logic [2:0] lv, logic [31:0] op);
    longint t, b;
    logic [PC_W-1:0] p;
    instr_res_t o;
    for (int i = 0; i < DEPTH; i++) mem_save[i] = mem[i];
    t = m_top;
    b = m_base;
    p = m_pc;
    o = exec_instr(fc, lv, op);
    for (int i = 0; i < DEPTH; i++) mem[i] = mem_save[i];
    m_top = t;
    m_base = b;
    m_pc = p;
    m_stopped = 0;
    m_hst = ST_OK;
    return o.hlt;
  endfunction

  task automatic put(fn_t f, logic [2:0] lv, logic [31:0] op, bit typed, logic [PC_W-1:0] pc);
    dir_rows.push_back('{f, lv, op, typed, pc});
  endtask

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // instruction sender
  initial begin
    logic [2:0] fc, lv;
    logic [31:0] op;
    instr_res_t exp_res;
    int n_items, gap, k, tries, calm_left;
    bit calm;
    rst = 1;
    in_valid = 0;
    function_code = 0;
    level_diff = 0;
    operand = 0;
    for (int i = 0; i < DEPTH; i++) mem[i] = 0;
    m_top = RESET_TOP;
    m_base = RESET_BASE;
    m_pc = 0;
    m_stopped = 0;
    m_hst = ST_OK;
    calm = 0;
    calm_left = 0;

    // directed program, typed expectations where obvious
    put(FN_LIT, 0, 32'h7fffffff, 1, 11'd1);
    put(FN_LIT, 0, 32'h80000000, 1, 11'd2);
    put(FN_OPR, 0, OPR_ADD, 0, 0);
    put(FN_OPR, 0, OPR_NEG, 0, 0);
    put(FN_LIT, 0, 32'h80000000, 0, 0);
    put(FN_LIT, 0, 32'hffffffff, 0, 0);
    put(FN_OPR, 0, OPR_DIV, 0, 0);        // most negative divided by minus one
    put(FN_OPR, 0, OPR_ODD, 0, 0);
    put(FN_LIT, 7, 32'hfffffffd, 0, 0);
    put(FN_OPR, 0, OPR_ODD, 0, 0);        // odd of a negative value
    put(FN_OPR, 0, OPR_SUB, 0, 0);
    put(FN_LIT, 0, 32'd2, 0, 0);
    put(FN_OPR, 0, OPR_MUL, 0, 0);
    put(FN_LIT, 0, 32'd5, 0, 0);
    put(FN_OPR, 0, OPR_LES, 0, 0);
    put(FN_OPR, 0, 32'd13, 0, 0);         // unknown sub-op is a no-op
    put(FN_STO, 0, 32'd0, 0, 0);
    put(FN_LOD, 7, 32'd3, 0, 0);
    put(FN_INT, 0, 32'd3, 0, 0);
    put(FN_CAL, 0, 32'd100, 0, 0);
    put(FN_JMP, 0, 32'd200, 1, 11'd200);
    put(FN_INT, 0, 32'd3, 0, 0);
    put(FN_LIT, 0, 32'd0, 0, 0);
    put(FN_JPC, 0, 32'd300, 0, 0);
    put(FN_OPR, 0, OPR_RET, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    n_items = dir_rows.size() + N_RANDOM + 6;
    for (int it = 0; it < n_items; it++) begin
      // pick the next instruction
      if (it < dir_rows.size()) begin
        fc = dir_rows[it].f;
        lv = dir_rows[it].lv;
        op = dir_rows[it].op;
      end else if (it < dir_rows.size() + N_RANDOM) begin
        tries = 0;
        do begin
          k = $urandom_range(0, 99);
          lv = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 1));
          if (k < 25) begin
            fc = FN_LIT;
            op = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 20)) - 32'd10;
          end else if (k < 55) begin
            fc = FN_OPR;
            op = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 15));
          end else if (k < 65) begin
            fc = FN_LOD;
            op = 32'($urandom_range(0, 12));
          end else if (k < 75) begin
            fc = FN_STO;
            op = 32'($urandom_range(0, 12));
          end else if (k < 80) begin
            fc = FN_CAL;
            op = $urandom;
          end else if (k < 88) begin
            fc = FN_INT;
            op = 32'($urandom_range(0, 8)) - 32'd3;
          end else if (k < 94) begin
            fc = FN_JMP;
            op = $urandom;
          end else begin
            fc = FN_JPC;
            op = $urandom;
          end
          tries++;
          if (tries > 40) begin
            fc = FN_JMP;
            lv = 0;
            op = 32'd1;
          end
        end while (tries <= 40 && halts_machine(fc, lv, op));
      end else begin
        // closing sequence: stack setup, one halting case, then instructions after the halt
        k = it - dir_rows.size() - N_RANDOM;
        lv = 0;
        case (k)
          0: begin fc = FN_INT; op = -32'(m_top); end
          1: begin fc = FN_LIT; op = 32'd9; end
          2: begin fc = FN_LIT; op = 32'd0; end
          3: begin
            case ($urandom_range(0, 2))
              0: begin fc = FN_OPR; op = OPR_DIV; end
              1: begin fc = FN_INT; op = 32'h80000000; end
              default: begin fc = FN_JMP; op = 32'd0; end
            endcase
          end
          default: begin
            fc = 3'($urandom_range(0, 7));
            lv = 3'($urandom_range(0, 7));
            op = $urandom;
          end
        endcase
      end

      exp_res = exec_instr(fc, lv, op);
      if (it < dir_rows.size() && dir_rows[it].typed)
        exp_res = '{dir_rows[it].pc, 1'b0, 1'b0, 32'd0, ST_OK};

      // idle gap, with calm stretches
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(5, 30);
      end
      calm_left--;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1;
      function_code <= fc;
      level_diff <= lv;
      operand <= op;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      pending_results.push_back(exp_res);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // result receiver backpressure
  initial begin
    int stall;
    out_ready = 0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each result transaction with the oldest prediction
  initial begin
    instr_res_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no instruction pending");
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (next_pc !== e.pc) begin
            $error("next_pc expected %0d actual %0d", e.pc, next_pc);
            errors++;
          end
          if (halted !== e.hlt) begin
            $error("halted expected %0d actual %0d", e.hlt, halted);
            errors++;
          end
          if (store_valid !== e.sto) begin
            $error("store_valid expected %0d actual %0d", e.sto, store_valid);
            errors++;
          end
          if (store_value !== e.val) begin
            $error("store_value expected %h actual %h", e.val, store_value);
            errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pl0_pkg.sv
src/pl0_div.sv
src/pl0_ctrl.sv
src/pl0_dp.sv
src/pl0_stack_machine_executor_unit.sv
dv/tb_pl0_stack_machine_executor_unit.sv
